/* hw/rtl/lagrange_interpolation_eval_macros.svh */
// Assertion macros shared by the interpolation evaluator RTL.
`ifndef LAGRANGE_INTERPOLATION_EVAL_MACROS_SVH
`define LAGRANGE_INTERPOLATION_EVAL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lie_pkg.sv */
// Package: command and status codes and the sequencer state type of the evaluator.
package lie_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_DUP = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    localparam int DIV_STEPS = 49;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_RD,
        S_DUP_CMP,
        S_EV_RD,
        S_EV_SETUP,
        S_EV_DIV,
        S_EV_FAC,
        S_EV_MUL,
        S_EV_SCL,
        S_TERM_RD,
        S_TERM_MUL,
        S_TERM_ACC,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/lagrange_interpolation_eval.sv */
// Top level: Lagrange interpolation evaluator over stored Q16.16 sample points.
//
// Load an item with i_cmd = load to write one (x, y) point into slot i_point_index;
// it takes effect at the accepting edge and yields no result. An evaluate item
// walks the first n = min(point_count, MAX_POINTS) points and produces one result
// on o_value/o_status, marked by o_done for exactly one cycle; the receiver cannot
// stall it, so capture it when o_done is high. Points live in two small synchronous
// memories (x with two read ports, y with one), registered and read the cycle before
// use. An evaluation first checks all point pairs for equal x (each pair is read, then
// compared; result value 0 with duplicate status on a hit), then for each i builds
// the basis product over j != i: each factor goes through a one-bit-per-cycle signed
// divider (49 steps) and one shared 32x32 multiplier. Busy stays high throughout an
// evaluation and no new item is taken meanwhile; a load does not raise busy.
// Configuration writes are always ready and should only be issued while idle.
module lagrange_interpolation_eval #(
    parameter int MAX_POINTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [2:0]         i_point_index,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_query_x,
    output logic               o_done,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data
);

`include "lagrange_interpolation_eval_macros.svh"

    localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int ACC_W = 48 + NW;
    localparam int CNT_W = $clog2(lie_pkg::DIV_STEPS + 1);

    // point store
    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];

    lie_pkg::t_state r_state, n_state;

    logic [3:0]              r_count;
    logic [NW-1:0]           r_n, r_i, r_j;
    logic signed [31:0]      r_q;
    logic signed [31:0]      r_rda, r_rdb, r_rdy;
    logic signed [31:0]      r_basis, r_factor;
    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_sat, r_dup;
    // divider
    logic [48:0]             r_dvd;
    logic [32:0]             r_dvs;
    logic [32:0]             r_rem;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;
    // result
    logic                    r_done;
    logic signed [31:0]      r_value;
    logic [1:0]              r_status;

    logic                    c_accept, c_load, c_eval;
    logic [IW-1:0]           c_addr_a, c_addr_b;
    logic [NW-1:0]           c_n;
    logic signed [32:0]      c_diff, c_den;
    logic [32:0]             c_diff_mag, c_den_mag;
    logic [33:0]             c_trial;
    logic                    c_qbit;
    logic signed [47:0]      c_scaled;
    logic                    c_scl_hi, c_scl_lo;
    logic                    c_acc_hi, c_acc_lo;
    logic [NW:0]             c_i_plus2;

    assign c_accept = start && !busy;
    assign c_load   = c_accept && (i_cmd == lie_pkg::CMD_LOAD)
                      && (int'(i_point_index) < MAX_POINTS);
    assign c_eval   = c_accept && (i_cmd == lie_pkg::CMD_EVAL);

    assign busy        = (r_state != lie_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_value     = r_value;
    assign o_status    = r_status;

    // clamp count to the store depth
    assign c_n = (int'(r_count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(r_count);

    // port A always reads slot i, port B slot j
    assign c_addr_a = r_i[IW-1:0];
    assign c_addr_b = r_j[IW-1:0];

    // numerator and denominator of one factor
    assign c_diff     = {r_q[31], r_q} - {r_rdb[31], r_rdb};
    assign c_den      = {r_rda[31], r_rda} - {r_rdb[31], r_rdb};
    assign c_diff_mag = c_diff[32] ? 33'(-c_diff) : 33'(c_diff);
    assign c_den_mag  = c_den[32]  ? 33'(-c_den)  : 33'(c_den);

    // restoring division step
    assign c_trial = {r_rem, r_dvd[48]};
    assign c_qbit  = (c_trial >= {1'b0, r_dvs});

    // product / 65536, truncated toward zero
    assign c_scaled = 48'(r_prod >>> 16)
                      + ((r_prod[63] && (r_prod[15:0] != 16'd0)) ? 48'sd1 : 48'sd0);
    assign c_scl_hi = (c_scaled > 48'sh0000_7FFF_FFFF);
    assign c_scl_lo = (c_scaled < 48'shFFFF_8000_0000);

    assign c_acc_hi = (r_acc > ACC_W'(48'sh0000_7FFF_FFFF));
    assign c_acc_lo = (r_acc < ACC_W'(48'shFFFF_8000_0000));

    assign c_i_plus2 = {1'b0, r_i} + (NW+1)'(2);

    // memories: write on load, registered reads every cycle
    always_ff @(posedge i_clk) begin
        if (c_load) begin
            mem_x[IW'(i_point_index)] <= i_point_x;
            mem_y[IW'(i_point_index)] <= i_point_y;
        end
        r_rda <= mem_x[c_addr_a];
        r_rdb <= mem_x[c_addr_b];
        r_rdy <= mem_y[c_addr_a];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lie_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lie_pkg::S_IDLE: begin
                if (c_eval) begin
                    if (c_n == '0) begin
                        n_state = lie_pkg::S_DONE;
                    end else if (c_n == NW'(1)) begin
                        n_state = lie_pkg::S_EV_RD;
                    end else begin
                        n_state = lie_pkg::S_DUP_RD;
                    end
                end
            end
            lie_pkg::S_DUP_RD:  n_state = lie_pkg::S_DUP_CMP;
            lie_pkg::S_DUP_CMP: begin
                if (r_rda == r_rdb) begin
                    n_state = lie_pkg::S_DONE;
                end else if ((r_j + 1'b1) != r_n || c_i_plus2 < {1'b0, r_n}) begin
                    n_state = lie_pkg::S_DUP_RD;
                end else begin
                    n_state = lie_pkg::S_EV_RD;
                end
            end
            lie_pkg::S_EV_RD: begin
                if (r_j == r_i) begin
                    n_state = ((r_j + 1'b1) == r_n) ? lie_pkg::S_TERM_RD : lie_pkg::S_EV_RD;
                end else begin
                    n_state = lie_pkg::S_EV_SETUP;
                end
            end
            lie_pkg::S_EV_SETUP: n_state = lie_pkg::S_EV_DIV;
            lie_pkg::S_EV_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = lie_pkg::S_EV_FAC;
                end
            end
            lie_pkg::S_EV_FAC: n_state = lie_pkg::S_EV_MUL;
            lie_pkg::S_EV_MUL: n_state = lie_pkg::S_EV_SCL;
            lie_pkg::S_EV_SCL: begin
                n_state = ((r_j + 1'b1) == r_n) ? lie_pkg::S_TERM_RD : lie_pkg::S_EV_RD;
            end
            lie_pkg::S_TERM_RD:  n_state = lie_pkg::S_TERM_MUL;
            lie_pkg::S_TERM_MUL: n_state = lie_pkg::S_TERM_ACC;
            lie_pkg::S_TERM_ACC: begin
                n_state = ((r_i + 1'b1) == r_n) ? lie_pkg::S_DONE : lie_pkg::S_EV_RD;
            end
            lie_pkg::S_DONE: n_state = lie_pkg::S_IDLE;
            default:         n_state = lie_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lie_pkg::S_IDLE: begin
                if (c_eval) begin
                    r_q     <= i_query_x;
                    r_n     <= c_n;
                    r_acc   <= '0;
                    r_sat   <= 1'b0;
                    r_dup   <= 1'b0;
                    r_basis <= 32'sh0001_0000;
                    r_i     <= '0;
                    // single point: skip the pair check and start at j = 0
                    r_j     <= (c_n == NW'(1)) ? NW'(0) : NW'(1);
                end
            end
            lie_pkg::S_DUP_RD: begin
            end
            lie_pkg::S_DUP_CMP: begin
                if (r_rda == r_rdb) begin
                    r_dup <= 1'b1;
                end else if ((r_j + 1'b1) != r_n) begin
                    r_j <= r_j + 1'b1;
                end else if (c_i_plus2 < {1'b0, r_n}) begin
                    r_i <= r_i + 1'b1;
                    r_j <= c_i_plus2[NW-1:0];
                end else begin
                    // pair check passed: start the first basis product
                    r_i     <= '0;
                    r_j     <= '0;
                    r_basis <= 32'sh0001_0000;
                end
            end
            lie_pkg::S_EV_RD: begin
                if (r_j == r_i) begin
                    r_j <= r_j + 1'b1;
                end
            end
            lie_pkg::S_EV_SETUP: begin
                r_dvd <= {c_diff_mag, 16'd0};
                r_dvs <= c_den_mag;
                r_rem <= '0;
                r_neg <= c_diff[32] ^ c_den[32];
                r_cnt <= CNT_W'(lie_pkg::DIV_STEPS);
            end
            lie_pkg::S_EV_DIV: begin
                r_rem <= c_qbit ? 33'(c_trial - {1'b0, r_dvs}) : c_trial[32:0];
                r_dvd <= {r_dvd[47:0], c_qbit};
                r_cnt <= r_cnt - 1'b1;
            end
            lie_pkg::S_EV_FAC: begin
                // saturate the quotient to the signed 32-bit range
                if (!r_neg && r_dvd > 49'h0_7FFF_FFFF) begin
                    r_factor <= 32'sh7FFF_FFFF;
                    r_sat    <= 1'b1;
                end else if (r_neg && r_dvd > 49'h0_8000_0000) begin
                    r_factor <= 32'sh8000_0000;
                    r_sat    <= 1'b1;
                end else begin
                    r_factor <= r_neg ? -$signed(r_dvd[31:0]) : $signed(r_dvd[31:0]);
                end
            end
            lie_pkg::S_EV_MUL: begin
                r_prod <= 64'(r_basis) * 64'(r_factor);
            end
            lie_pkg::S_EV_SCL: begin
                if (c_scl_hi) begin
                    r_basis <= 32'sh7FFF_FFFF;
                    r_sat   <= 1'b1;
                end else if (c_scl_lo) begin
                    r_basis <= 32'sh8000_0000;
                    r_sat   <= 1'b1;
                end else begin
                    r_basis <= c_scaled[31:0];
                end
                r_j <= r_j + 1'b1;
            end
            lie_pkg::S_TERM_RD: begin
            end
            lie_pkg::S_TERM_MUL: begin
                r_prod <= 64'(r_basis) * 64'(r_rdy);
            end
            lie_pkg::S_TERM_ACC: begin
                r_acc   <= r_acc + ACC_W'(c_scaled);
                r_i     <= r_i + 1'b1;
                r_j     <= '0;
                r_basis <= 32'sh0001_0000;
            end
            lie_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == lie_pkg::S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lie_pkg::S_DONE) begin
            if (r_dup) begin
                r_value  <= '0;
                r_status <= lie_pkg::STAT_DUP;
            end else begin
                if (c_acc_hi) begin
                    r_value <= 32'sh7FFF_FFFF;
                end else if (c_acc_lo) begin
                    r_value <= 32'sh8000_0000;
                end else begin
                    r_value <= r_acc[31:0];
                end
                r_status <= (r_sat || c_acc_hi || c_acc_lo) ? lie_pkg::STAT_SAT
                                                             : lie_pkg::STAT_OK;
            end
        end
    end

    `LIE_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "done strobe held two cycles")
    `LIE_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, c_eval, busy, "evaluate item did not raise busy")
    `LIE_ASSERT_NOW(a_dup_zero, i_clk, i_rst_n, o_done && o_status == lie_pkg::STAT_DUP, o_value == 32'sd0, "duplicate result not zero")
    `LIE_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_done, o_status == lie_pkg::STAT_OK || o_status == lie_pkg::STAT_DUP || o_status == lie_pkg::STAT_SAT, "undefined status code")
    `LIE_ASSERT_NOW(a_div_count, i_clk, i_rst_n, r_state == lie_pkg::S_EV_DIV, r_cnt != '0, "divider ran past its last step")

endmodule

/* bench/tb_top.sv */
// Testbench for the Lagrange interpolation evaluator: directed and random items, self-checking.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS  = 8;
    // Longest quiet stretch: a full eight-point evaluation plus the longest sender
    // gap, taken several times over.
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_interp_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cmd;
    logic [2:0]         i_point_index;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_query_x;
    logic               o_done;
    logic signed [31:0] o_value;
    logic [1:0]         o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_data;

    // Mirror of the block's point memories and point count.
    logic signed [31:0] shadow_x [NUM_SLOTS];
    logic signed [31:0] shadow_y [NUM_SLOTS];
    logic [3:0]         shadow_count;

    t_interp_result     pending_results[$];
    int                 mismatch_count;
    int                 items_sent;
    int                 quiet_cycles;
    bit                 no_gaps;

    lagrange_interpolation_eval #(.MAX_POINTS(NUM_SLOTS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_query_x     (i_query_x),
        .o_done        (o_done),
        .o_value       (o_value),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Clamp to the signed 32-bit range and flag saturation.
    function automatic longint clip32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Interpolate over the first n shadow points at q; truncating division throughout.
    function automatic t_interp_result interpolate(logic signed [31:0] q);
        t_interp_result res;
        int     n;
        bit     sat;
        longint acc;
        longint basis;
        longint num;
        longint den;
        longint factor;
        n   = (shadow_count > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_count);
        sat = 1'b0;
        acc = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                if (shadow_x[i] == shadow_x[j]) begin
                    res.value  = '0;
                    res.status = lie_pkg::STAT_DUP;
                    return res;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            basis = 65536;
            for (int j = 0; j < n; j++) begin
                if (j != i) begin
                    num    = (longint'(q) - longint'(shadow_x[j])) * 65536;
                    den    = longint'(shadow_x[i]) - longint'(shadow_x[j]);
                    factor = clip32(num / den, sat);
                    basis  = clip32((basis * factor) / 65536, sat);
                end
            end
            acc += (basis * longint'(shadow_y[i])) / 65536;
        end
        acc        = clip32(acc, sat);
        res.value  = acc[31:0];
        res.status = sat ? lie_pkg::STAT_SAT : lie_pkg::STAT_OK;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare every result against the oldest expectation.
    always @(posedge i_clk) begin
        t_interp_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {o_status, 30'd0}, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_value !== want.value)
                    report_mismatch("value", o_value, want.value);
                if (o_status !== want.status)
                    report_mismatch("status", {30'd0, o_status}, {30'd0, want.status});
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Hold the start line low for a random gap: mostly short, sometimes long.
    task automatic idle_gap();
        int len;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 55)
            len = 0;
        else if (pick < 90)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(10, 40);
        if (len > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (len - 1) @(negedge i_clk);
        end
    endtask

    // Send one item; update the shadow and queue the expectation at the accepting edge.
    task automatic send_item(logic cmd, logic [2:0] slot, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] q);
        idle_gap();
        @(negedge i_clk);
        start         = 1'b1;
        i_cmd         = cmd;
        i_point_index = slot;
        i_point_x     = px;
        i_point_y     = py;
        i_query_x     = q;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        if (cmd == lie_pkg::CMD_LOAD) begin
            shadow_x[slot] = px;
            shadow_y[slot] = py;
        end else begin
            pending_results = {pending_results, interpolate(q)};
        end
        items_sent++;
    endtask

    task automatic load_point(int slot, logic signed [31:0] px, logic signed [31:0] py);
        send_item(lie_pkg::CMD_LOAD, slot[2:0], px, py, $urandom);
    endtask

    task automatic eval_at(logic signed [31:0] q);
        send_item(lie_pkg::CMD_EVAL, 3'($urandom), $urandom, $urandom, q);
    endtask

    // Drop start, wait for every result and for the block to settle.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    // Write the point count while the block is idle.
    task automatic write_count(logic [3:0] n);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = n;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        shadow_count = n;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = 4'($urandom);
    endtask

    // Random x: distinct integer part per slot, random fraction.
    task automatic load_clean_points(int n);
        bit taken [61];
        int k;
        foreach (taken[t])
            taken[t] = 1'b0;
        for (int s = 0; s < n; s++) begin
            do k = $urandom_range(0, 60) - 30; while (taken[k + 30]);
            taken[k + 30] = 1'b1;
            load_point(s, (k <<< 16) + $urandom_range(0, 65535),
                       $signed($urandom_range(0, 200 * 65536)) - 100 * 65536);
        end
    endtask

    task automatic test_directed();
        // Fill every slot first so that no evaluation reads an unwritten entry.
        for (int s = 0; s < NUM_SLOTS; s++)
            load_point(s, s <<< 16, (s * 3 - 7) <<< 16);
        eval_at(32'sh0002_8000);
        eval_at(32'sh7fff_ffff);
        eval_at(32'sh8000_0000);
        // Extreme ordinates and abscissas.
        load_point(6, 32'sh7fff_ffff, 32'sh7fff_ffff);
        load_point(7, 32'sh8000_0000, 32'sh8000_0000);
        eval_at(32'sh0000_0000);
        write_count(4'd2);
        eval_at(32'sh0001_0000);
        eval_at(32'sh7fff_ffff);
        write_count(4'd1);
        eval_at(32'sh1234_5678);
        write_count(4'd0);
        eval_at(32'sh0000_0000);
        // Count above the slot total clamps to all slots.
        write_count(4'd15);
        eval_at(32'sh0000_8000);
        // Duplicate abscissa takes priority over saturation.
        load_point(3, 32'sh0001_0000, 32'sh7fff_ffff);
        eval_at(32'sh7fff_ffff);
        load_point(3, 32'sh0003_0000, 32'sh0000_0000);
        write_count(4'd8);
        eval_at(32'shffff_0000);
    endtask

    task automatic test_random();
        int n;
        int pick;
        int evals;
        while (items_sent < 1000) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      n = $urandom_range(1, 4);
            else if (pick < 88) n = $urandom_range(5, 7);
            else if (pick < 93) n = 8;
            else if (pick < 96) n = 0;
            else                n = $urandom_range(9, 15);
            write_count(n[3:0]);
            no_gaps = ($urandom_range(0, 3) == 0);
            evals   = (n > 5) ? $urandom_range(1, 3) : $urandom_range(2, 8);
            if ($urandom_range(0, 9) < 7) begin
                // Well-formed: fresh distinct points, then queries near them.
                load_clean_points((n > NUM_SLOTS) ? NUM_SLOTS : n);
                repeat (evals)
                    eval_at($signed($urandom_range(0, 80 * 65536)) - 40 * 65536);
            end else begin
                // Noise: full-range loads, some duplicate x, full-range queries.
                repeat (evals) begin
                    if ($urandom_range(0, 1))
                        load_point($urandom_range(0, 7),
                                   ($urandom_range(0, 3) == 0) ?
                                       shadow_x[$urandom_range(0, 7)] : $urandom,
                                   $urandom);
                    eval_at($urandom);
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = lie_pkg::CMD_LOAD;
        i_point_index = '0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_query_x     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        mismatch_count = 0;
        items_sent     = 0;
        no_gaps        = 1'b0;
        shadow_count   = 4'd8;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            shadow_x[s] = '0;
            shadow_y[s] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random();

        drain();
        repeat (50) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
